// ===== rtl/crh_pkg.sv =====
// Shared constants, types and helpers for the calibrated RGB to HSL converter.
`default_nettype none
package crh_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COUNT_W       = 16;
  localparam int HUE_W         = 9;
  localparam int PCT_W         = 7;
  localparam int CFG_IDX_W     = 1;
  localparam int ROOT_W        = 7;
  localparam int ROOT_STEPS    = ROOT_W;
  localparam int HUE_STEPS     = HUE_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 1'b1;

  localparam logic [COUNT_W-1:0] WINDOW_LOW_RST  = 16'd0;
  localparam logic [COUNT_W-1:0] WINDOW_HIGH_RST = 16'd65535;

  localparam logic [HUE_W-1:0] HUE_MAX   = 9'd359;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
  localparam logic [HUE_W-1:0] SEXT_STEP = 9'd60;
  localparam logic [13:0]      SAT_SCALE = 14'd10000;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE,
    SEC_RED_WRAP
  } sector_t;

  function automatic logic [HUE_W-1:0] sector_base(input sector_t sec);
    logic [HUE_W-1:0] base;
    case (sec)
      SEC_RED:      base = 9'd0;
      SEC_GREEN:    base = 9'd120;
      SEC_BLUE:     base = 9'd240;
      SEC_RED_WRAP: base = 9'd360;
      default:      base = 9'd0;
    endcase
    return base;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/crh_norm.sv =====
// Pipelined restoring divider that normalizes one clamped count into the window.
`default_nettype none
module crh_norm #(
  parameter int FRAC_BITS = crh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [crh_pkg::COUNT_W-1:0]  offset,
  input  wire logic [crh_pkg::COUNT_W-1:0]  span,
  output logic      [FRAC_BITS:0]           quo
);
  import crh_pkg::*;

  localparam int QW = FRAC_BITS + 1;

  logic [COUNT_W-1:0] rem_q   [0:FRAC_BITS];
  logic [COUNT_W-1:0] span_q  [0:FRAC_BITS];
  logic [QW-1:0]      quo_q   [0:FRAC_BITS];
  logic [COUNT_W:0]   trial   [0:FRAC_BITS];
  logic [COUNT_W-1:0] span_s  [0:FRAC_BITS];
  logic [QW-1:0]      quo_s   [0:FRAC_BITS];

  for (genvar k = 0; k <= FRAC_BITS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign trial[k]  = {1'b0, offset};
      assign span_s[k] = span;
      assign quo_s[k]  = '0;
    end else begin : g_next
      assign trial[k]  = {rem_q[k-1], 1'b0};
      assign span_s[k] = span_q[k-1];
      assign quo_s[k]  = quo_q[k-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        span_q[k] <= span_s[k];
        if (trial[k] >= {1'b0, span_s[k]}) begin
          rem_q[k] <= COUNT_W'(trial[k] - {1'b0, span_s[k]});
          quo_q[k] <= {quo_s[k][QW-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[k][COUNT_W-1:0];
          quo_q[k] <= {quo_s[k][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[FRAC_BITS];

endmodule
`default_nettype wire

// ===== rtl/crh_hue_div.sv =====
// Pipelined restoring divider that turns the sextant numerator into whole degrees.
`default_nettype none
module crh_hue_div #(
  parameter int FRAC_BITS = crh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     en,
  input  wire logic [FRAC_BITS+crh_pkg::HUE_W:0]        num,
  input  wire logic [FRAC_BITS:0]                       delta,
  output logic      [crh_pkg::HUE_W-1:0]                hue
);
  import crh_pkg::*;

  localparam int NW = FRAC_BITS + 1;

  logic [NW-1:0]    rem_q [0:HUE_STEPS-1];
  logic [NW-1:0]    dlt_q [0:HUE_STEPS-1];
  logic [HUE_W-1:0] low_q [0:HUE_STEPS-1];
  logic [HUE_W-1:0] quo_q [0:HUE_STEPS-1];
  logic [NW-1:0]    rem_s [0:HUE_STEPS-1];
  logic [NW-1:0]    dlt_s [0:HUE_STEPS-1];
  logic [HUE_W-1:0] low_s [0:HUE_STEPS-1];
  logic [HUE_W-1:0] quo_s [0:HUE_STEPS-1];
  logic [NW:0]      trial [0:HUE_STEPS-1];

  for (genvar k = 0; k < HUE_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign rem_s[k] = num[NW+HUE_W-1:HUE_W];
      assign low_s[k] = num[HUE_W-1:0];
      assign dlt_s[k] = delta;
      assign quo_s[k] = '0;
    end else begin : g_next
      assign rem_s[k] = rem_q[k-1];
      assign low_s[k] = low_q[k-1];
      assign dlt_s[k] = dlt_q[k-1];
      assign quo_s[k] = quo_q[k-1];
    end

    assign trial[k] = {rem_s[k], low_s[k][HUE_W-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        dlt_q[k] <= dlt_s[k];
        low_q[k] <= {low_s[k][HUE_W-2:0], 1'b0};
        if (trial[k] >= {1'b0, dlt_s[k]}) begin
          rem_q[k] <= NW'(trial[k] - {1'b0, dlt_s[k]});
          quo_q[k] <= {quo_s[k][HUE_W-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[k][NW-1:0];
          quo_q[k] <= {quo_s[k][HUE_W-2:0], 1'b0};
        end
      end
    end
  end

  assign hue = quo_q[HUE_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/crh_sat_root.sv =====
// Pipelined bit-by-bit root search for the saturation percentage.
`default_nettype none
module crh_sat_root #(
  parameter int FRAC_BITS = crh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       en,
  input  wire logic [FRAC_BITS+2*crh_pkg::ROOT_W:0]       lim,
  input  wire logic [FRAC_BITS:0]                         denom,
  output logic      [crh_pkg::ROOT_W-1:0]                 root
);
  import crh_pkg::*;

  localparam int NW   = FRAC_BITS + 1;
  localparam int SQW  = 2 * ROOT_W;
  localparam int LIMW = NW + SQW;

  logic [ROOT_W-1:0] s_q   [0:HUE_STEPS-1];
  logic [SQW-1:0]    sq_q  [0:HUE_STEPS-1];
  logic [LIMW-1:0]   lim_q [0:HUE_STEPS-1];
  logic [NW-1:0]     den_q [0:HUE_STEPS-1];
  logic [ROOT_W-1:0] s_s   [0:HUE_STEPS-1];
  logic [SQW-1:0]    sq_s  [0:HUE_STEPS-1];
  logic [LIMW-1:0]   lim_s [0:HUE_STEPS-1];
  logic [NW-1:0]     den_s [0:HUE_STEPS-1];

  for (genvar k = 0; k < HUE_STEPS; k++) begin : g_step
    if (k == 0) begin : g_first
      assign s_s[k]   = '0;
      assign sq_s[k]  = '0;
      assign lim_s[k] = lim;
      assign den_s[k] = denom;
    end else begin : g_next
      assign s_s[k]   = s_q[k-1];
      assign sq_s[k]  = sq_q[k-1];
      assign lim_s[k] = lim_q[k-1];
      assign den_s[k] = den_q[k-1];
    end

    if (k < ROOT_STEPS) begin : g_test
      localparam int E = ROOT_STEPS - 1 - k;
      logic [SQW-1:0]  cand_sq;
      logic [LIMW-1:0] prod;

      // Squaring the candidate incrementally keeps one multiplier per stage.
      assign cand_sq = sq_s[k] + (SQW'(s_s[k]) << (E + 1)) + (SQW'(1) << (2 * E));
      assign prod    = LIMW'(cand_sq) * LIMW'(den_s[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          lim_q[k] <= lim_s[k];
          den_q[k] <= den_s[k];
          if (prod <= lim_s[k]) begin
            s_q[k]  <= s_s[k] | (ROOT_W'(1) << E);
            sq_q[k] <= cand_sq;
          end else begin
            s_q[k]  <= s_s[k];
            sq_q[k] <= sq_s[k];
          end
        end
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          lim_q[k] <= lim_s[k];
          den_q[k] <= den_s[k];
          s_q[k]   <= s_s[k];
          sq_q[k]  <= sq_s[k];
        end
      end
    end
  end

  assign root = s_q[HUE_STEPS-1];

endmodule
`default_nettype wire

// ===== rtl/calibrated_rgb_to_hsl.sv =====
// Top level of the calibrated RGB to HSL converter.
// One word enters every cycle while the pipeline advances, and the whole pipeline
// advances together when the result register is empty or its word is taken.
// Synchronous reset clears the window registers to 0 and 65535 and all valid bits.
`default_nettype none
module calibrated_rgb_to_hsl #(
  parameter int FRAC_BITS = crh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [crh_pkg::COUNT_W-1:0]   red_count,
  input  wire logic [crh_pkg::COUNT_W-1:0]   green_count,
  input  wire logic [crh_pkg::COUNT_W-1:0]   blue_count,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [crh_pkg::HUE_W-1:0]     hue_deg,
  output logic      [crh_pkg::PCT_W-1:0]     saturation_pct,
  output logic      [crh_pkg::PCT_W-1:0]     lightness_pct,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [crh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [crh_pkg::COUNT_W-1:0]   cfg_data
);
  import crh_pkg::*;

  localparam int NW    = FRAC_BITS + 1;
  localparam int NUMW  = NW + HUE_W;
  localparam int LIMW  = NW + 2 * ROOT_W;
  localparam int LGW   = NW + 1 + PCT_W;
  localparam int DEPTH = FRAC_BITS + 13;

  function automatic logic [COUNT_W-1:0] offset_of(input logic [COUNT_W-1:0] c,
                                                   input logic [COUNT_W-1:0] lo,
                                                   input logic [COUNT_W-1:0] hi);
    logic [COUNT_W-1:0] cl;
    cl = (c < lo) ? lo : ((c > hi) ? hi : c);
    return cl - lo;
  endfunction

  logic [COUNT_W-1:0] window_low;
  logic [COUNT_W-1:0] window_high;
  logic [DEPTH-1:0]   vld;
  logic               adv;

  logic [COUNT_W-1:0] off_r, off_g, off_b, span;
  logic [NW-1:0]      nr, ng, nb;

  logic [NW-1:0]      mx, mn, mag;
  sector_t            sec;
  logic               neg;
  logic [NW-1:0]      m_delta, m_mag;
  logic [NW:0]        m_sum;
  sector_t            m_sec;
  logic               m_neg;

  logic [NW:0]        one, sum_dev;
  logic [LGW-1:0]     lig_prod;
  logic [7:0]         lig_raw;
  logic [NUMW-1:0]    p_num;
  logic [NW-1:0]      p_delta, p_denom;
  logic [LIMW-1:0]    p_lim;
  logic               p_grey;
  logic [PCT_W-1:0]   p_lig;

  logic               grey_d [0:HUE_STEPS-1];
  logic [PCT_W-1:0]   lig_d  [0:HUE_STEPS-1];
  logic [HUE_W-1:0]   hue_raw;
  logic [ROOT_W-1:0]  root;

  assign cfg_ready = 1'b1;
  assign adv       = !vld[DEPTH-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_low  <= WINDOW_LOW_RST;
      window_high <= WINDOW_HIGH_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LOW:  window_low  <= cfg_data;
        REG_WINDOW_HIGH: window_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // An empty or inverted window divides zero by one so every channel comes out zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (window_high <= window_low) begin
        off_r <= '0;
        off_g <= '0;
        off_b <= '0;
        span  <= COUNT_W'(1);
      end else begin
        off_r <= offset_of(red_count, window_low, window_high);
        off_g <= offset_of(green_count, window_low, window_high);
        off_b <= offset_of(blue_count, window_low, window_high);
        span  <= window_high - window_low;
      end
    end
  end

  crh_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_r (
    .clk(clk), .en(adv), .offset(off_r), .span(span), .quo(nr)
  );
  crh_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_g (
    .clk(clk), .en(adv), .offset(off_g), .span(span), .quo(ng)
  );
  crh_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_b (
    .clk(clk), .en(adv), .offset(off_b), .span(span), .quo(nb)
  );

  // Red wins ties for the largest channel, then green.
  always_comb begin
    mx = nr;
    mn = nr;
    if (ng > mx) mx = ng;
    if (nb > mx) mx = nb;
    if (ng < mn) mn = ng;
    if (nb < mn) mn = nb;
    if (mx == nr) begin
      if (ng < nb) begin
        sec = SEC_RED_WRAP;
        neg = 1'b1;
        mag = nb - ng;
      end else begin
        sec = SEC_RED;
        neg = 1'b0;
        mag = ng - nb;
      end
    end else if (mx == ng) begin
      sec = SEC_GREEN;
      neg = (nb < nr);
      mag = (nb < nr) ? nr - nb : nb - nr;
    end else begin
      sec = SEC_BLUE;
      neg = (nr < ng);
      mag = (nr < ng) ? ng - nr : nr - ng;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_delta <= mx - mn;
      m_sum   <= {1'b0, mx} + {1'b0, mn};
      m_sec   <= sec;
      m_neg   <= neg;
      m_mag   <= mag;
    end
  end

  assign one      = (NW + 1)'(1) << FRAC_BITS;
  assign sum_dev  = (m_sum >= one) ? m_sum - one : one - m_sum;
  assign lig_prod = LGW'(m_sum) * LGW'(PCT_MAX);
  assign lig_raw  = lig_prod[LGW-1:NW];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (m_neg) begin
        p_num <= NUMW'(sector_base(m_sec)) * NUMW'(m_delta)
                 - NUMW'(SEXT_STEP) * NUMW'(m_mag);
      end else begin
        p_num <= NUMW'(sector_base(m_sec)) * NUMW'(m_delta)
                 + NUMW'(SEXT_STEP) * NUMW'(m_mag);
      end
      p_delta <= m_delta;
      p_lim   <= LIMW'(m_delta) * LIMW'(SAT_SCALE);
      p_denom <= NW'(one - sum_dev);
      p_grey  <= (m_delta == '0);
      p_lig   <= (lig_raw > 8'(PCT_MAX)) ? PCT_MAX : lig_raw[PCT_W-1:0];
    end
  end

  crh_hue_div #(.FRAC_BITS(FRAC_BITS)) u_hue_div (
    .clk(clk), .en(adv), .num(p_num), .delta(p_delta), .hue(hue_raw)
  );

  crh_sat_root #(.FRAC_BITS(FRAC_BITS)) u_sat_root (
    .clk(clk), .en(adv), .lim(p_lim), .denom(p_denom), .root(root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      grey_d[0] <= p_grey;
      lig_d[0]  <= p_lig;
      for (int i = 1; i < HUE_STEPS; i++) begin
        grey_d[i] <= grey_d[i-1];
        lig_d[i]  <= lig_d[i-1];
      end
    end
  end

  always_comb begin
    if (grey_d[HUE_STEPS-1]) begin
      hue_deg        = '0;
      saturation_pct = '0;
    end else begin
      hue_deg        = (hue_raw > HUE_MAX) ? HUE_MAX : hue_raw;
      saturation_pct = (root > PCT_MAX) ? PCT_MAX : root;
    end
    lightness_pct = lig_d[HUE_STEPS-1];
  end

endmodule
`default_nettype wire

// ===== rtl/crh_checker.sv =====
// Port-level checks for the calibrated RGB to HSL converter and their binding.
`default_nettype none
module crh_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [crh_pkg::HUE_W-1:0] hue_deg,
  input wire logic [crh_pkg::PCT_W-1:0] saturation_pct,
  input wire logic [crh_pkg::PCT_W-1:0] lightness_pct
);
  import crh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_deg)
      && $stable(saturation_pct) && $stable(lightness_pct))
    else $error("result word changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue_deg <= HUE_MAX)
    else $error("hue out of range");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> saturation_pct <= PCT_MAX && lightness_pct <= PCT_MAX)
    else $error("percentage out of range");

  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output stall");

endmodule

bind calibrated_rgb_to_hsl crh_checker u_crh_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .hue_deg(hue_deg),
  .saturation_pct(saturation_pct),
  .lightness_pct(lightness_pct)
);
`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the calibrated RGB to HSL converter.
`default_nettype none
module tb_top;
  import crh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int LAT = FB + 13;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [COUNT_W-1:0] red;
    logic [COUNT_W-1:0] green;
    logic [COUNT_W-1:0] blue;
  } sample_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] light;
  } hsl_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [COUNT_W-1:0] red_count = '0, green_count = '0, blue_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [HUE_W-1:0] hue_deg;
  logic [PCT_W-1:0] saturation_pct, lightness_pct;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_LOW;
  logic [COUNT_W-1:0] cfg_data = '0;

  calibrated_rgb_to_hsl u_top (.*);

  always #5 clk = ~clk;

  logic [COUNT_W-1:0] win_lo = WINDOW_LOW_RST, win_hi = WINDOW_HIGH_RST;
  sample_t pending_samples[$];
  hsl_t expected_hsl[$];
  int errors = 0;
  int results_seen = 0;
  longint cycles = 0;
  bit driver_pause = 0;
  bit sink_hold = 0;
  int hold_count = 0;

  function automatic longint unsigned norm_count(logic [COUNT_W-1:0] c);
    longint unsigned v = c;
    if (win_hi <= win_lo) return 0;
    if (v < win_lo) v = win_lo;
    if (v > win_hi) v = win_hi;
    return ((v - win_lo) << FB) / (win_hi - win_lo);
  endfunction

  function automatic hsl_t convert_sample(sample_t s);
    longint unsigned one = 64'd1 << FB;
    longint unsigned r, g, b, mx, mn, d, sum, sum_dev, den, hue, sat, lig;
    longint signed num;
    hsl_t h;
    r = norm_count(s.red); g = norm_count(s.green); b = norm_count(s.blue);
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn; sum = mx + mn; hue = 0; sat = 0;
    if (d != 0) begin
      if (mx == r) begin
        num = (g < b) ? 360 * d - 60 * (b - g) : 60 * (g - b);
      end else if (mx == g) begin
        num = 120 * d + 60 * $signed(b - r);
      end else begin
        num = 240 * d + 60 * $signed(r - g);
      end
      hue = longint'(num) / d;
      sum_dev = (sum >= one) ? sum - one : one - sum;
      den = (sum_dev <= one) ? one - sum_dev : 0;
      if (den != 0)
        while (sat < 100 && (sat + 1) * (sat + 1) * den <= 10000 * d) sat++;
    end
    lig = (100 * sum) >> (FB + 1);
    if (lig > 100) lig = 100;
    if (hue > 359) hue = 359;
    h.hue = HUE_W'(hue); h.sat = PCT_W'(sat); h.light = PCT_W'(lig);
    return h;
  endfunction

  // Driver: random gap before each word, predicts at acceptance.
  int in_gap = 0;
  always @(posedge clk) begin : driver
    int gap;
    bit idle;
    gap = in_gap;
    idle = !in_valid;
    if (in_valid && in_ready) begin
      expected_hsl.push_back(convert_sample({red_count, green_count, blue_count}));
      pending_samples.delete(0);
      gap = $urandom_range(0, 12) * $urandom_range(0, 1);
      idle = 1'b1;
    end else if (idle && gap > 0) begin
      gap = gap - 1;
    end
    if (idle) begin
      if (!rst && !driver_pause && gap == 0 && pending_samples.size() > 0) begin
        red_count <= pending_samples[0].red;
        green_count <= pending_samples[0].green;
        blue_count <= pending_samples[0].blue;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_gap <= gap;
  end

  // Monitor: random stall per word, long hold-off on request.
  int out_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_hsl.size() == 0) begin
        $display("%0t: unexpected word hue=%0d sat=%0d light=%0d", $time,
                 hue_deg, saturation_pct, lightness_pct);
        errors <= errors + 1;
      end else begin
        if (expected_hsl[0].hue !== hue_deg ||
            expected_hsl[0].sat !== saturation_pct ||
            expected_hsl[0].light !== lightness_pct) begin
          $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                   expected_hsl[0].hue, expected_hsl[0].sat, expected_hsl[0].light,
                   hue_deg, saturation_pct, lightness_pct);
          errors <= errors + 1;
        end
        expected_hsl.delete(0);
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (sink_hold) begin
      out_ready <= 1'b0;
      hold_count <= hold_count + 1;
    end else if (out_valid && out_ready) begin
      out_gap = $urandom_range(0, 1) ? $urandom_range(0, 12) : 0;
      out_ready <= (out_gap == 0);
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ready <= (out_gap == 0);
    end else begin
      out_ready <= 1'b1;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_samples.size() > 0 || in_valid || expected_hsl.size() > 0)
      @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW_LOW) win_lo = val; else win_hi = val;
  endtask

  function automatic logic [COUNT_W-1:0] near_window();
    int unsigned sel = $urandom_range(0, 9);
    if (sel == 0) return win_lo;
    if (sel == 1) return win_hi;
    if (sel == 2) return COUNT_W'($urandom);
    if (win_hi > win_lo) return COUNT_W'($urandom_range(win_lo, win_hi));
    return COUNT_W'($urandom);
  endfunction

  task automatic push_sample(logic [COUNT_W-1:0] r, logic [COUNT_W-1:0] g,
                             logic [COUNT_W-1:0] b);
    pending_samples.push_back({r, g, b});
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) begin
        logic [COUNT_W-1:0] v = near_window();
        push_sample(v, v, v);
      end else begin
        push_sample(near_window(), near_window(), near_window());
      end
    end
  endtask

  logic [COUNT_W-1:0] lo_set[6] = '{16'd0, 16'd1000, 16'd0, 16'd65534, 16'd5000, 16'd300};
  logic [COUNT_W-1:0] hi_set[6] = '{16'd65535, 16'd60000, 16'd1, 16'd65535, 16'd5000, 16'd200};

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed words: extremes, grey, ties and every sextant.
    push_sample(0, 0, 0);
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_sample(16'hFFFF, 0, 0);
    push_sample(0, 16'hFFFF, 0);
    push_sample(0, 0, 16'hFFFF);
    push_sample(16'hFFFF, 16'hFFFF, 0);
    push_sample(0, 16'hFFFF, 16'hFFFF);
    push_sample(16'hFFFF, 0, 16'hFFFF);
    push_sample(16'hFFFF, 16'h8000, 16'h1000);
    push_sample(16'hFFFF, 16'h1000, 16'h8000);
    push_sample(16'h8000, 16'hFFFF, 16'h1000);
    push_sample(16'h1000, 16'hFFFF, 16'h8000);
    push_sample(16'h1000, 16'h8000, 16'hFFFF);
    push_sample(16'h8000, 16'h1000, 16'hFFFF);
    push_sample(16'h5555, 16'hAAAA, 16'h0001);
    push_sample(16'h8000, 16'h8000, 16'h8000);
    wait_drained();
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_WINDOW_LOW, lo_set[p]);
      write_reg(REG_WINDOW_HIGH, hi_set[p]);
      push_sample(0, win_lo, 16'hFFFF);
      push_sample(win_hi, 0, win_lo);
      random_phase((p == 0 || p == 1 || p == 5) ? 400 : 60);
      if (p == 1) begin
        sink_hold = 1;
        while (hold_count < 150) @(posedge clk);
        sink_hold = 0;
      end
      if (p == 2) begin
        while (pending_samples.size() > 30) @(posedge clk);
        driver_pause = 1;
        while (expected_hsl.size() > 0 || in_valid) @(posedge clk);
        driver_pause = 0;
      end
      wait_drained();
    end
    $display("Checked %0d words across 6 window settings, incl. empty and inverted.",
             results_seen);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
